// ===== hw/rtl/scws_pkg.sv =====
package scws_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned AMOUNT_W   = 9;
  localparam int unsigned COUNT_W    = 4;

  localparam logic [AMOUNT_W-1:0] AMOUNT_FULL = 9'd256;
  localparam logic [COUNT_W-1:0]  COUNT_MIN   = 4'd1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOLD_AMOUNT = 2'd0,
    CFG_FOLD_COUNT  = 2'd1
  } cfg_idx_e;

  // effective fold settings, already saturated
  typedef struct packed {
    logic                fold_on;
    logic [AMOUNT_W-1:0] amount;
    logic [COUNT_W-1:0]  count;
  } fold_cfg_t;

endpackage

// ===== hw/rtl/scws_front.sv =====
module scws_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [SAMPLE_WIDTH-1:0]   sample_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic                      neg_o,
  output logic [SAMPLE_WIDTH+2:0]   den_o,
  output logic [SAMPLE_WIDTH+2:0]   rem_o,
  output logic [SAMPLE_WIDTH-1:0]   lo_o
);

  localparam int unsigned W    = SAMPLE_WIDTH;
  localparam int unsigned F    = W - 4;
  localparam int unsigned AW   = F + 2;
  localparam int unsigned SqW  = 2 * AW;
  localparam int unsigned X2W  = F + 4;
  localparam int unsigned BW   = F + 6;
  localparam int unsigned NumW = AW + BW;
  localparam int unsigned DW   = F + 7;

  localparam logic [W-1:0]   Lim    = W'(3) << F;
  localparam logic [SqW-1:0] SqHalf = SqW'(1) << (F - 1);

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;

  // stage 1: magnitude, clamp to 3.0
  logic [W-1:0]  mag;
  logic [AW-1:0] a1_d, a1_q;
  logic          neg1_q;

  assign mag  = sample_i[W-1] ? (~sample_i + W'(1)) : sample_i;
  assign a1_d = (mag > Lim) ? Lim[AW-1:0] : mag[AW-1:0];

  // stage 2: x^2 in Q.F, rounded half up
  logic [SqW-1:0] sq;
  logic [X2W-1:0] x2_q;
  logic [AW-1:0]  a2_q;
  logic           neg2_q;

  assign sq = (SqW'(a1_q) * SqW'(a1_q)) + SqHalf;

  // stage 3: numerator and denominator, quotient scaled by 4
  logic [BW-1:0]   base;
  logic [NumW-1:0] num;
  logic [NumW+1:0] num4;
  logic [DW-1:0]   den_d;

  assign base  = (BW'(27) << F) + BW'(x2_q);
  assign num   = NumW'(a2_q) * NumW'(base);
  assign num4  = {num, 2'b00};
  assign den_d = (DW'(27) << F) + (DW'(x2_q) << 3) + DW'(x2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      neg1_q <= sample_i[W-1];
      a1_q   <= a1_d;
    end
    if (en2) begin
      neg2_q <= neg1_q;
      a2_q   <= a1_q;
      x2_q   <= sq[SqW-1:F];
    end
    if (en3) begin
      neg_o <= neg2_q;
      den_o <= den_d;
      rem_o <= DW'(num4[NumW+1:W]);
      lo_o  <= num4[W-1:0];
    end
  end

endmodule

// ===== hw/rtl/scws_div_cell.sv =====
module scws_div_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic                      neg_i,
  input  logic [SAMPLE_WIDTH+2:0]   den_i,
  input  logic [SAMPLE_WIDTH+2:0]   rem_i,
  input  logic [SAMPLE_WIDTH-1:0]   lo_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic                      neg_o,
  output logic [SAMPLE_WIDTH+2:0]   den_o,
  output logic [SAMPLE_WIDTH+2:0]   rem_o,
  output logic [SAMPLE_WIDTH-1:0]   lo_o
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned DW = W + 3;

  logic          valid_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [W-1:0]  lo_d;

  // one restoring step: next dividend bit in, quotient bit out at the bottom
  assign trial = {rem_i, lo_i[W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};
  assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign lo_d  = {lo_i[W-2:0], ge};

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      neg_o <= neg_i;
      den_o <= den_i;
      rem_o <= rem_d;
      lo_o  <= lo_d;
    end
  end

endmodule

// ===== hw/rtl/scws_back.sv =====
module scws_back #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scws_pkg::fold_cfg_t        cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       neg_i,
  input  logic [SAMPLE_WIDTH+2:0]    den_i,
  input  logic [SAMPLE_WIDTH+2:0]    rem_i,
  input  logic [SAMPLE_WIDTH-1:0]    lo_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [SAMPLE_WIDTH-1:0]    sample_o
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned G  = W - 2;
  localparam int unsigned YW = W + 3;
  localparam int unsigned PW = YW + scws_pkg::AMOUNT_W + 1;

  localparam logic [W:0]            CapQ   = (W + 1)'(1) << G;
  localparam logic [YW-1:0]         KHalf  = YW'(1) << (G + 1);
  localparam logic signed [YW-1:0]  One    = YW'(1) << G;
  localparam logic signed [YW-1:0]  TwoOne = YW'(1) << (G + 1);
  localparam logic [PW-1:0]         PHalf  = PW'(128);

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v5_q;

  // stage 1: round quotient half up, limit to 1.0, restore sign
  logic          up;
  logic [W:0]    qr;
  logic [W:0]    cmag;
  logic [W-1:0]  c1_d;
  logic signed [W-1:0] c1_q, c2_q, c3_q, c4_q;

  assign up   = {rem_i, 1'b0} >= {1'b0, den_i};
  assign qr   = {1'b0, lo_i} + (W + 1)'(up);
  assign cmag = (qr > CapQ) ? CapQ : qr;
  assign c1_d = neg_i ? (~cmag[W-1:0] + W'(1)) : cmag[W-1:0];

  // stage 2: scale by fold count
  logic signed [YW-1:0] c1_ext;
  logic signed [YW-1:0] n_ext;
  logic signed [YW-1:0] y_d, y2_q;

  assign c1_ext = YW'(c1_q);
  assign n_ext  = $signed(YW'(cfg_i.count));
  assign y_d    = c1_ext * n_ext;

  // stage 3: wrap into +/-2, reflect about +/-1, difference to clipped value
  logic [YW-1:0]        ymag;
  logic [YW-1:0]        ksum;
  logic [YW-1:0]        kq;
  logic signed [YW-1:0] w;
  logic signed [YW-1:0] f;
  logic signed [YW-1:0] c2_ext;
  logic signed [YW-1:0] d_d, d3_q;

  assign ymag   = y2_q[YW-1] ? (~y2_q + YW'(1)) : y2_q;
  assign ksum   = ymag + KHalf;
  assign kq     = {ksum[YW-1:G+2], {(G + 2){1'b0}}};
  assign w      = y2_q[YW-1] ? (y2_q + $signed(kq)) : (y2_q - $signed(kq));
  assign c2_ext = YW'(c2_q);
  assign d_d    = f - c2_ext;

  always_comb begin
    if (w > One) begin
      f = TwoOne - w;
    end else if (w < -One) begin
      f = -TwoOne - w;
    end else begin
      f = w;
    end
  end

  // stage 4: weight by fold amount
  logic signed [PW-1:0] d_ext;
  logic signed [PW-1:0] amt_ext;
  logic signed [PW-1:0] p_d, p4_q;

  assign d_ext   = PW'(d3_q);
  assign amt_ext = $signed(PW'(cfg_i.amount));
  assign p_d     = d_ext * amt_ext;

  // stage 5: round /256 half away from 0, add to clipped value if fold on
  logic [PW-1:0] pm;
  logic [PW-1:0] t;
  logic [W-1:0]  res_d;

  assign pm = p4_q[PW-1] ? (~p4_q + PW'(1)) : p4_q;
  assign t  = (pm + PHalf) >> 8;

  always_comb begin
    if (!cfg_i.fold_on) begin
      res_d = c4_q;
    end else if (p4_q[PW-1]) begin
      res_d = c4_q - t[W-1:0];
    end else begin
      res_d = c4_q + t[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q <= c1_d;
    end
    if (en2) begin
      c2_q <= c1_q;
      y2_q <= y_d;
    end
    if (en3) begin
      c3_q <= c2_q;
      d3_q <= d_d;
    end
    if (en4) begin
      c4_q <= c3_q;
      p4_q <= p_d;
    end
    if (en5) begin
      sample_o <= res_d;
    end
  end

endmodule

// ===== hw/rtl/soft_clip_wavefold_shaper_unit.sv =====
// Soft clip and wavefold shaper.
//
// Input channel: in_valid_i / in_stall_o carry one driven sample (signed Q3.12
// at the default width) per request. Output channel: out_valid_o / out_stall_i
// carry one shaped sample (signed Q1.14) per request. A request moves at a
// clock edge where valid is high and stall is low.
//
// One sample is accepted every cycle while in_stall_o is low. The pipeline
// has three front stages (clamp, square, num/den), one divider cell per
// quotient bit, and five back stages ending in the output register.
//
// The config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes fold_amount and
// fold_count; write it only while no sample is in flight.
//
// Reset empties the pipeline and sets fold_amount to 0, fold_count to 1.
// When the receiver stalls, the output holds and each stage holds once it is
// full; empty stages keep filling, so in_stall_o rises only when every stage
// holds a sample.
module soft_clip_wavefold_shaper_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [scws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]             driven_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]             shaped_sample_o
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned DW = W + 3;

  logic [scws_pkg::AMOUNT_W-1:0] amount_q;
  logic [scws_pkg::COUNT_W-1:0]  count_q;
  scws_pkg::fold_cfg_t           fold_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= '0;
      count_q  <= scws_pkg::COUNT_MIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scws_pkg::CFG_FOLD_AMOUNT: amount_q <= cfg_wdata_i[scws_pkg::AMOUNT_W-1:0];
        scws_pkg::CFG_FOLD_COUNT:  count_q  <= cfg_wdata_i[scws_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fold_cfg.fold_on = (amount_q != '0);
    fold_cfg.amount  = (amount_q > scws_pkg::AMOUNT_FULL) ? scws_pkg::AMOUNT_FULL : amount_q;
    if (count_q < scws_pkg::COUNT_MIN) begin
      fold_cfg.count = scws_pkg::COUNT_MIN;
    end else if (count_q > scws_pkg::COUNT_MAX) begin
      fold_cfg.count = scws_pkg::COUNT_MAX;
    end else begin
      fold_cfg.count = count_q;
    end
  end

  // links between front, divider cells and back; link 0 is the front output
  logic         lnk_valid [W+1];
  logic         lnk_ready [W+1];
  logic         lnk_neg   [W+1];
  logic [DW-1:0] lnk_den  [W+1];
  logic [DW-1:0] lnk_rem  [W+1];
  logic [W-1:0]  lnk_lo   [W+1];
  logic          front_ready;

  assign in_stall_o = !front_ready;

  scws_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (front_ready),
    .sample_i (driven_sample_i),
    .valid_o  (lnk_valid[0]),
    .ready_i  (lnk_ready[0]),
    .neg_o    (lnk_neg[0]),
    .den_o    (lnk_den[0]),
    .rem_o    (lnk_rem[0]),
    .lo_o     (lnk_lo[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    scws_div_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lnk_valid[i]),
      .ready_o (lnk_ready[i]),
      .neg_i   (lnk_neg[i]),
      .den_i   (lnk_den[i]),
      .rem_i   (lnk_rem[i]),
      .lo_i    (lnk_lo[i]),
      .valid_o (lnk_valid[i+1]),
      .ready_i (lnk_ready[i+1]),
      .neg_o   (lnk_neg[i+1]),
      .den_o   (lnk_den[i+1]),
      .rem_o   (lnk_rem[i+1]),
      .lo_o    (lnk_lo[i+1])
    );
  end

  scws_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (fold_cfg),
    .valid_i  (lnk_valid[W]),
    .ready_o  (lnk_ready[W]),
    .neg_i    (lnk_neg[W]),
    .den_i    (lnk_den[W]),
    .rem_i    (lnk_rem[W]),
    .lo_i     (lnk_lo[W]),
    .valid_o  (out_valid_o),
    .ready_i  (!out_stall_i),
    .sample_o (shaped_sample_o)
  );

endmodule
